@@ design/key_event_to_note_tracker_assert.svh @@
// Assertion macros for the key event to note tracker checker.
// Both macros sample on clock and are switched off while reset is high.
`ifndef KEY_EVENT_TO_NOTE_TRACKER_ASSERT_SVH
`define KEY_EVENT_TO_NOTE_TRACKER_ASSERT_SVH

// Same-cycle implication
`define KETNT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define KETNT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/ketnt_pkg.sv @@
// Shared types, codes and constants for the key event to note tracker.
// No dependencies; all files but the macro header use its scoped names.
package ketnt_pkg;

   localparam int MAX_HELD = 8;
   localparam int IDX_W    = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
   localparam int CNT_W    = $clog2(MAX_HELD + 1);

   // result kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ON   = 2'd1;
   localparam logic [1:0] KIND_OFF  = 2'd2;
   localparam logic [1:0] KIND_MENU = 2'd3;

   // menu keys
   localparam logic [1:0] MENU_UP   = 2'd0;
   localparam logic [1:0] MENU_DOWN = 2'd1;
   localparam logic [1:0] MENU_OK   = 2'd2;
   localparam logic [1:0] MENU_BACK = 2'd3;

   // HID usage codes with a fixed role
   localparam logic [7:0] KC_UP     = 8'h52;
   localparam logic [7:0] KC_DOWN   = 8'h51;
   localparam logic [7:0] KC_ENTER  = 8'h28;
   localparam logic [7:0] KC_ESCAPE = 8'h29;
   localparam logic [7:0] KC_BKSP   = 8'h2A;
   localparam logic [7:0] KC_LEFT   = 8'h50;
   localparam logic [7:0] KC_RIGHT  = 8'h4F;
   localparam logic [7:0] KC_SPACE  = 8'h2C;

   localparam logic signed [7:0] TRANS_MAX = 8'sd36;
   localparam logic signed [7:0] TRANS_MIN = -8'sd36;
   localparam logic signed [7:0] OCTAVE    = 8'sd12;
   localparam logic signed [8:0] NOTE_BASE = 9'sd60;
   localparam logic signed [8:0] NOTE_TOP  = 9'sd127;

   typedef struct packed {
      logic [7:0] hid_code;
      logic       pressed;
   } req_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [6:0] note;
      logic [1:0] menu_key;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] key_code;
      logic [6:0] note;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] semi;
   } semi_type;

   // Keyboard layout: bottom row gives the lower octave, top row the upper.
   function automatic semi_type semi_lookup(input logic [7:0] code);
      semi_type r;
      r.hit  = 1'b1;
      r.semi = 5'd0;
      unique case (code)
         8'h1D: r.semi = 5'd0;
         8'h16: r.semi = 5'd1;
         8'h1B: r.semi = 5'd2;
         8'h07: r.semi = 5'd3;
         8'h06: r.semi = 5'd4;
         8'h19: r.semi = 5'd5;
         8'h0A: r.semi = 5'd6;
         8'h05: r.semi = 5'd7;
         8'h0B: r.semi = 5'd8;
         8'h11: r.semi = 5'd9;
         8'h0D: r.semi = 5'd10;
         8'h10: r.semi = 5'd11;
         8'h14: r.semi = 5'd12;
         8'h1F: r.semi = 5'd13;
         8'h1A: r.semi = 5'd14;
         8'h20: r.semi = 5'd15;
         8'h08: r.semi = 5'd16;
         8'h15: r.semi = 5'd17;
         8'h22: r.semi = 5'd18;
         8'h17: r.semi = 5'd19;
         8'h23: r.semi = 5'd20;
         8'h1C: r.semi = 5'd21;
         8'h24: r.semi = 5'd22;
         8'h18: r.semi = 5'd23;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

@@ design/ketnt_table.sv @@
// Held-key table: one write port, one registered read port.
// Uses ketnt_pkg for the entry and request types.
module ketnt_table (
   input  logic                   clock,
   input  ketnt_pkg::mem_req_type mem_req,
   output ketnt_pkg::entry_type   rd_data
);

   ketnt_pkg::entry_type mem [ketnt_pkg::MAX_HELD];
   ketnt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ketnt_ctrl.sv @@
// Sequencer for the tracker: decodes a key beat, walks the held table one
// entry at a time and drives the result register. Uses ketnt_pkg.
module ketnt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ketnt_pkg::req_type     req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ketnt_pkg::rsp_type     rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_wdata,
   output ketnt_pkg::mem_req_type mem_req,
   input  ketnt_pkg::entry_type   rd_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_ADD  = 3'd3;
   localparam logic [2:0] S_MVRD = 3'd4;
   localparam logic [2:0] S_MVWR = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;

   localparam logic [1:0] MODE_ALL   = 2'd0;
   localparam logic [1:0] MODE_PRESS = 2'd1;
   localparam logic [1:0] MODE_REL   = 2'd2;

   logic [2:0]                    state_ff, state_in;
   logic [1:0]                    mode_ff, mode_in;
   logic [ketnt_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [ketnt_pkg::CNT_W-1:0]   count_ff, count_in;
   logic signed [6:0]             trans_ff, trans_in;
   logic                          enabled_ff, enabled_in;
   logic [7:0]                    code_ff, code_in;
   logic [6:0]                    note_ff, note_in;
   ketnt_pkg::rsp_type            pend_ff, pend_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ketnt_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   ketnt_pkg::semi_type           semi;
   logic signed [7:0]             trans_wide, trans_up, trans_dn;
   logic signed [8:0]             note_sum;
   logic [6:0]                    note_clamped;
   logic                          idx_is_last;
   logic                          has_entries;
   logic                          not_full;
   ketnt_pkg::rsp_type            none_rsp;

   always_comb begin
      semi       = ketnt_pkg::semi_lookup(req_data.hid_code);
      trans_wide = $signed({trans_ff[6], trans_ff});
      trans_up   = trans_wide + ketnt_pkg::OCTAVE;
      trans_dn   = trans_wide - ketnt_pkg::OCTAVE;
      if (trans_up > ketnt_pkg::TRANS_MAX) begin
         trans_up = ketnt_pkg::TRANS_MAX;
      end
      if (trans_dn < ketnt_pkg::TRANS_MIN) begin
         trans_dn = ketnt_pkg::TRANS_MIN;
      end
      note_sum = ketnt_pkg::NOTE_BASE + $signed({4'b0000, semi.semi})
               + $signed({{2{trans_ff[6]}}, trans_ff});
      if (note_sum < 9'sd0) begin
         note_clamped = 7'd0;
      end else if (note_sum > ketnt_pkg::NOTE_TOP) begin
         note_clamped = 7'd127;
      end else begin
         note_clamped = note_sum[6:0];
      end
      idx_is_last = (ketnt_pkg::CNT_W'(idx_ff) + ketnt_pkg::CNT_W'(1)) == count_ff;
      has_entries = count_ff != '0;
      not_full    = count_ff < ketnt_pkg::CNT_W'(ketnt_pkg::MAX_HELD);
      none_rsp    = '{event_kind: ketnt_pkg::KIND_NONE, note: 7'd0,
                      menu_key: ketnt_pkg::MENU_UP, last: 1'b1};
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      trans_in     = trans_ff;
      code_in      = code_ff;
      note_in      = note_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      enabled_in   = csr_valid ? csr_wdata : enabled_ff;
      mem_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               code_in  = req_data.hid_code;
               note_in  = note_clamped;
               pend_in  = none_rsp;
               mode_in  = MODE_PRESS;
               idx_in   = '0;
               state_in = S_EMIT;
               case (req_data.hid_code) inside
                  ketnt_pkg::KC_UP: begin
                     if (req_data.pressed) begin
                        pend_in.event_kind = ketnt_pkg::KIND_MENU;
                        pend_in.menu_key   = ketnt_pkg::MENU_UP;
                     end
                  end
                  ketnt_pkg::KC_DOWN: begin
                     if (req_data.pressed) begin
                        pend_in.event_kind = ketnt_pkg::KIND_MENU;
                        pend_in.menu_key   = ketnt_pkg::MENU_DOWN;
                     end
                  end
                  ketnt_pkg::KC_ENTER: begin
                     if (req_data.pressed) begin
                        pend_in.event_kind = ketnt_pkg::KIND_MENU;
                        pend_in.menu_key   = ketnt_pkg::MENU_OK;
                     end
                  end
                  ketnt_pkg::KC_ESCAPE, ketnt_pkg::KC_BKSP: begin
                     if (req_data.pressed) begin
                        pend_in.event_kind = ketnt_pkg::KIND_MENU;
                        pend_in.menu_key   = ketnt_pkg::MENU_BACK;
                     end
                  end
                  ketnt_pkg::KC_LEFT: begin
                     if (req_data.pressed && trans_dn != trans_wide) begin
                        trans_in = trans_dn[6:0];
                        mode_in  = MODE_ALL;
                        if (has_entries) begin
                           state_in = S_RD;
                        end
                     end
                  end
                  ketnt_pkg::KC_RIGHT: begin
                     if (req_data.pressed && trans_up != trans_wide) begin
                        trans_in = trans_up[6:0];
                        mode_in  = MODE_ALL;
                        if (has_entries) begin
                           state_in = S_RD;
                        end
                     end
                  end
                  ketnt_pkg::KC_SPACE: begin
                     if (req_data.pressed) begin
                        mode_in = MODE_ALL;
                        if (has_entries) begin
                           state_in = S_RD;
                        end
                     end
                  end
                  default: begin
                     if (semi.hit && enabled_ff) begin
                        if (req_data.pressed) begin
                           if (not_full) begin
                              mode_in  = MODE_PRESS;
                              state_in = has_entries ? S_RD : S_ADD;
                           end
                        end else if (has_entries) begin
                           mode_in  = MODE_REL;
                           state_in = S_RD;
                        end
                     end
                  end
               endcase
            end
         end
         S_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_ff;
            state_in        = S_CHK;
         end
         S_CHK: begin
            case (mode_ff)
               MODE_ALL: begin
                  pend_in  = '{event_kind: ketnt_pkg::KIND_OFF, note: rd_data.note,
                               menu_key: ketnt_pkg::MENU_UP, last: idx_is_last};
                  state_in = S_EMIT;
               end
               MODE_PRESS: begin
                  if (rd_data.key_code == code_ff) begin
                     // key already sounding: drop the press
                     pend_in  = none_rsp;
                     state_in = S_EMIT;
                  end else if (idx_is_last) begin
                     state_in = S_ADD;
                  end else begin
                     idx_in   = idx_ff + ketnt_pkg::IDX_W'(1);
                     state_in = S_RD;
                  end
               end
               default: begin
                  if (rd_data.key_code == code_ff) begin
                     pend_in  = '{event_kind: ketnt_pkg::KIND_OFF, note: rd_data.note,
                                  menu_key: ketnt_pkg::MENU_UP, last: 1'b1};
                     count_in = count_ff - ketnt_pkg::CNT_W'(1);
                     state_in = S_MVRD;
                  end else if (idx_is_last) begin
                     pend_in  = none_rsp;
                     state_in = S_EMIT;
                  end else begin
                     idx_in   = idx_ff + ketnt_pkg::IDX_W'(1);
                     state_in = S_RD;
                  end
               end
            endcase
         end
         S_ADD: begin
            mem_req.wr_en            = 1'b1;
            mem_req.wr_addr          = count_ff[ketnt_pkg::IDX_W-1:0];
            mem_req.wr_data.key_code = code_ff;
            mem_req.wr_data.note     = note_ff;
            count_in = count_ff + ketnt_pkg::CNT_W'(1);
            pend_in  = '{event_kind: ketnt_pkg::KIND_ON, note: note_ff,
                         menu_key: ketnt_pkg::MENU_UP, last: 1'b1};
            state_in = S_EMIT;
         end
         S_MVRD: begin
            // count already points at the old last entry
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = count_ff[ketnt_pkg::IDX_W-1:0];
            state_in        = S_MVWR;
         end
         S_MVWR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = idx_ff;
            mem_req.wr_data = rd_data;
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               if (mode_ff == MODE_ALL && !pend_ff.last) begin
                  idx_in   = idx_ff + ketnt_pkg::IDX_W'(1);
                  state_in = S_RD;
               end else begin
                  if (mode_ff == MODE_ALL) begin
                     count_in = '0;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_PRESS;
         idx_ff       <= '0;
         count_ff     <= '0;
         trans_ff     <= '0;
         enabled_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         trans_ff     <= trans_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      note_ff     <= note_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

@@ design/key_event_to_note_tracker.sv @@
// Key event to note tracker: turns keyboard key beats into note-on, note-off
// and menu-key results. One key beat is taken at a time; req_stall stays high
// until its last result has been loaded into the output register. A menu key,
// an unmapped code, a note key while disabled, a press with the table full or
// a release of a non-note key gives a single result without the table. A note
// press searches the held entries for the key and adds it if it is not held.
// A note release searches up to the match, then moves the old last entry
// into the freed slot. A release-all (space, or a transpose change) gives
// a note-off for each held note, or a no-effect result with none held. The
// pace is set by the held-key table, read one entry at a time through its
// single registered read port; output stalls hold the sequencer in its emit
// state. The enable register is written through the csr port, which is
// always ready.
module key_event_to_note_tracker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ketnt_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ketnt_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_wdata
);

   ketnt_pkg::mem_req_type mem_req;
   ketnt_pkg::entry_type   rd_data;

   ketnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   ketnt_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

@@ design/ketnt_checker.sv @@
// Port-level checks for the key event to note tracker, bound to the top.
// Uses ketnt_pkg and the macros in key_event_to_note_tracker_assert.svh.
`include "key_event_to_note_tracker_assert.svh"

module ketnt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ketnt_pkg::rsp_type rsp_data
);

   // a stalled result beat holds
   `KETNT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

   // an accepted key beat always makes the block busy
   `KETNT_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "req accepted but block not busy")

   `KETNT_ASSERT_NOW(a_none_is_last, rsp_valid && rsp_data.event_kind == ketnt_pkg::KIND_NONE, rsp_data.last, "no-effect beat without last")

   `KETNT_ASSERT_NOW(a_menu_fields, rsp_valid && rsp_data.event_kind == ketnt_pkg::KIND_MENU, rsp_data.last && rsp_data.note == 7'd0, "menu beat with note or not last")

   `KETNT_ASSERT_NOW(a_menu_key_zero, rsp_valid && rsp_data.event_kind != ketnt_pkg::KIND_MENU, rsp_data.menu_key == ketnt_pkg::MENU_UP, "menu key set on a non-menu beat")

endmodule

bind key_event_to_note_tracker ketnt_checker u_ketnt_checker (.*);
